>>> rtl/scan_ring_buffer_with_angle_lookup_defines.svh
// Assertion macros for the scan ring buffer; both are clocked on clock and disabled in reset.
`ifndef SCAN_RING_BUFFER_WITH_ANGLE_LOOKUP_DEFINES_SVH
`define SCAN_RING_BUFFER_WITH_ANGLE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define SRB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scan buffer check failed");

// next-cycle implication
`define SRB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scan buffer check failed");

`endif

>>> rtl/srb_pkg.sv
// Shared types, constants and the points table for the scan ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

   localparam int DEF_BUFFER_SLOTS = 8;
   localparam int DEF_MAX_POINTS   = 2048;

   localparam int SAMPLE_W  = 16;
   localparam int ANGLE_W   = 15;
   localparam int RES_W     = 4;
   localparam int POINTS_W  = 11;   // holds 1800/r + 1 for r = 1
   localparam int IDX_W     = 11;   // index into one scan, at most 1800
   localparam int PROD_W    = 25;   // angle * (points-1) + half, below 2**25

   localparam logic [ANGLE_W-1:0] ANGLE_MAX  = ANGLE_W'(18000);
   localparam logic [PROD_W-1:0]  ANGLE_HALF = PROD_W'(18000 / 2);

   // floor(n / 18000) == (n * RECIP) >> RECIP_SHIFT, exact for n < 2**PROD_W
   localparam int RECIP_SHIFT = 40;
   localparam int RECIP_W     = 26;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(61083980);

   localparam logic [RES_W-1:0] RES_RESET = RES_W'(10);

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_RESOLUTION = 1'b0;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_ANGLE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MOP_NONE,
      MOP_WRITE,
      MOP_READ_POP,
      MOP_READ_DIST
   } mem_op_type;

   // result sideband carried alongside the memory access
   typedef struct packed {
      logic       zero;
      status_type status;
      logic       last;
   } side_type;

   // samples per scan, 1800/r + 1, resolution clamped to 1..10
   function automatic logic [POINTS_W-1:0] points_lookup(input logic [RES_W-1:0] r);
      logic [POINTS_W-1:0] p;
      case (r) inside
         4'd0, 4'd1: p = POINTS_W'(1801);
         4'd2:       p = POINTS_W'(901);
         4'd3:       p = POINTS_W'(601);
         4'd4:       p = POINTS_W'(451);
         4'd5:       p = POINTS_W'(361);
         4'd6:       p = POINTS_W'(301);
         4'd7:       p = POINTS_W'(258);
         4'd8:       p = POINTS_W'(226);
         4'd9:       p = POINTS_W'(201);
         default:    p = POINTS_W'(181);
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> rtl/scan_ring_buffer_with_angle_lookup.sv
// Top level: ring buffer of range scans with pop and angle lookup.
//
//   channel  dir  handshake        payload
//   req      in   valid / stall    command, sample_value, sample_last, angle
//   rsp      out  valid / stall    value, status, scan_last
//   csr      in   APB write/read   resolution_tenths at byte address 0
//
// One word in, one word out; a word is taken every cycle while rsp is not stalled.
// Stages in order: state update, sample RAM access, result register.
// The single RAM port (one write or one read per word) sets the rate of one per cycle while rsp is not stalled.
// Synchronous reset empties the buffer at once; no clearing pass over the sample RAM.
// A stalled result holds the whole pipe, and req_stall rises in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "scan_ring_buffer_with_angle_lookup_defines.svh"

module scan_ring_buffer_with_angle_lookup #(
   parameter int BUFFER_SLOTS = srb_pkg::DEF_BUFFER_SLOTS,
   parameter int MAX_POINTS   = srb_pkg::DEF_MAX_POINTS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_command,
   input  wire logic [srb_pkg::SAMPLE_W-1:0]      req_sample_value,
   input  wire logic                              req_sample_last,
   input  wire logic [srb_pkg::ANGLE_W-1:0]       req_angle,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [srb_pkg::SAMPLE_W-1:0]      rsp_value,
   output logic      [1:0]                        rsp_status,
   output logic                                   rsp_scan_last,

   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [srb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [srb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [srb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import srb_pkg::*;

   localparam int SLOT_W = $clog2(BUFFER_SLOTS);
   localparam int POS_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = SLOT_W + POS_W;
   localparam int DEPTH  = BUFFER_SLOTS * (2 ** POS_W);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef struct packed {
      mem_op_type         op;
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   pos;
      logic [SAMPLE_W-1:0] wdata;
      logic [PROD_W-1:0]  prod;
      logic [CNT_W-1:0]   len;
      side_type           side;
   } stage_a_type;

   function automatic logic [CNT_W-1:0] cap_points(input logic [POINTS_W-1:0] p);
      if (32'(p) > MAX_POINTS) begin
         return CNT_W'(MAX_POINTS);
      end
      return CNT_W'(p);
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      if (s == SLOT_W'(BUFFER_SLOTS - 1)) begin
         return '0;
      end
      return s + 1'b1;
   endfunction

   localparam logic [CNT_W-1:0] POINTS_RESET = cap_points(points_lookup(RES_RESET));

   // buffer state
   logic [RES_W-1:0]  res_ff;
   logic [CNT_W-1:0]  points_ff, points_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic              empty_ff, empty_in;
   logic [CNT_W-1:0]  wpos_ff, wpos_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in;
   logic [CNT_W-1:0]  len_ff [BUFFER_SLOTS];

   logic              len_we;
   logic [SLOT_W-1:0] len_wslot;
   logic [CNT_W-1:0]  len_wval;
   logic [SLOT_W-1:0] len_rslot;
   logic [CNT_W-1:0]  len_rd;

   // pipeline
   logic        advance, accept;
   logic        a_valid_ff;
   stage_a_type a_ff, a_in;
   logic        b_valid_ff;
   side_type    b_ff, b_in;
   logic        rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff;
   logic        rsp_last_ff;

   // memory side
   logic                ram_en, ram_we;
   logic [ADDR_W-1:0]   ram_addr;
   logic [POS_W-1:0]    ram_pos;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [IDX_W-1:0]    dist_idx;

   logic                csr_wr;
   logic [IDX_W-1:0]    pm1;
   cmd_type             cmd;
   logic [SLOT_W-1:0]   slot_new;
   logic [CNT_W-1:0]    rpos_inc;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   assign cmd  = cmd_type'(req_command);
   assign pm1  = IDX_W'(points_ff) - 1'b1;

   // ---------------- csr ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2:2] == REG_RESOLUTION);
   assign csr_prdata = (csr_paddr[2:2] == REG_RESOLUTION) ? CSR_DATA_W'(res_ff) : '0;
   assign points_in  = cap_points(points_lookup(csr_pwdata[RES_W-1:0]));

   // ---------------- command decode and state update ----------------
   assign len_rslot = (cmd == CMD_POP) ? oldest_ff : newest_ff;
   assign len_rd    = len_ff[len_rslot];
   assign rpos_inc  = CNT_W'(rpos_ff) + CNT_W'(1);

   always_comb begin
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      empty_in  = empty_ff;
      wpos_in   = wpos_ff;
      rpos_in   = rpos_ff;
      len_we    = 1'b0;
      len_wslot = newest_ff;
      len_wval  = '0;
      slot_new  = newest_ff;

      a_in             = '0;
      a_in.op          = MOP_NONE;
      a_in.wdata       = req_sample_value;
      a_in.side.zero   = 1'b1;
      a_in.side.status = ST_OK;
      a_in.side.last   = 1'b0;

      unique case (cmd)
         CMD_PUSH: begin
            if (wpos_ff == '0) begin
               // first sample opens a slot, displacing the oldest scan when full
               if (empty_ff) begin
                  slot_new = oldest_ff;
                  empty_in = 1'b0;
                  rpos_in  = '0;
               end else begin
                  slot_new = next_slot(newest_ff);
                  if (slot_new == oldest_ff) begin
                     oldest_in = next_slot(oldest_ff);
                     rpos_in   = '0;
                  end
               end
               newest_in = slot_new;
               len_we    = 1'b1;
               len_wval  = '0;
            end
            len_wslot = slot_new;
            if (wpos_ff < points_ff) begin
               a_in.op   = MOP_WRITE;
               a_in.slot = slot_new;
               a_in.pos  = wpos_ff[POS_W-1:0];
               wpos_in   = wpos_ff + 1'b1;
               len_we    = 1'b1;
               len_wval  = wpos_ff + 1'b1;
            end
            if (req_sample_last) begin
               wpos_in = '0;
            end
         end
         CMD_POP: begin
            if (empty_ff) begin
               a_in.side.status = ST_EMPTY;
            end else begin
               a_in.op        = MOP_READ_POP;
               a_in.slot      = oldest_ff;
               a_in.pos       = rpos_ff;
               a_in.side.zero = (CNT_W'(rpos_ff) >= len_rd);
               if (rpos_inc >= points_ff) begin
                  a_in.side.last = 1'b1;
                  rpos_in        = '0;
                  if (oldest_ff == newest_ff) begin
                     // freeing the only slot also ends a push in progress
                     empty_in = 1'b1;
                     wpos_in  = '0;
                  end else begin
                     oldest_in = next_slot(oldest_ff);
                  end
               end else begin
                  rpos_in = rpos_inc[POS_W-1:0];
               end
            end
         end
         CMD_READ: begin
            if (empty_ff) begin
               a_in.side.status = ST_EMPTY;
            end else if (req_angle > ANGLE_MAX) begin
               a_in.side.status = ST_BAD_ANGLE;
            end else begin
               a_in.op   = MOP_READ_DIST;
               a_in.slot = newest_ff;
               a_in.prod = PROD_W'(req_angle) * PROD_W'(pm1);
               a_in.len  = len_rd;
            end
         end
         CMD_CLEAR: begin
            empty_in = 1'b1;
            wpos_in  = '0;
            rpos_in  = '0;
         end
         default: ;
      endcase
   end

   // ---------------- memory stage ----------------
   srb_angle_index u_angle_index (
      .prod (a_ff.prod),
      .idx  (dist_idx)
   );

   assign ram_pos  = (a_ff.op == MOP_READ_DIST) ? POS_W'(dist_idx) : a_ff.pos;
   assign ram_addr = {a_ff.slot, ram_pos};
   assign ram_en   = advance && a_valid_ff && (a_ff.op != MOP_NONE);
   assign ram_we   = (a_ff.op == MOP_WRITE);

   srb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_sample_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (a_ff.wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      b_in = a_ff.side;
      if (a_ff.op == MOP_READ_DIST) begin
         // a short scan reads as zero beyond its stored length
         b_in.zero = (CMP_W'(dist_idx) >= CMP_W'(a_ff.len));
      end
   end

   assign rsp_value_in = b_ff.zero ? '0 : ram_rdata;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff       <= RES_RESET;
         points_ff    <= POINTS_RESET;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         empty_ff     <= 1'b1;
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            res_ff    <= csr_pwdata[RES_W-1:0];
            points_ff <= points_in;
         end
         if (accept) begin
            oldest_ff <= oldest_in;
            newest_ff <= newest_in;
            empty_ff  <= empty_in;
            wpos_ff   <= wpos_in;
            rpos_ff   <= rpos_in;
         end
         if (advance) begin
            a_valid_ff   <= accept;
            b_valid_ff   <= a_valid_ff;
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   // slot lengths: every slot's length is written when the slot is opened, before any read of it
   always_ff @(posedge clock) begin
      if (accept && len_we) begin
         len_ff[len_wslot] <= len_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= a_in;
      end
      if (advance) begin
         b_ff          <= b_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= b_ff.status;
         rsp_last_ff   <= b_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_scan_last = rsp_last_ff;

   // ---------------- checks ----------------
   `SRB_ASSERT_NOW(a_empty_no_push, empty_ff, wpos_ff == '0)
   `SRB_ASSERT_NOW(a_err_is_zero, b_valid_ff && (b_ff.status != ST_OK), b_ff.zero)
   `SRB_ASSERT_NOW(a_ram_held_in_stall, !advance, !ram_en)
   `SRB_ASSERT_NEXT(a_clear_empties, accept && (cmd == CMD_CLEAR), empty_ff && (rpos_ff == '0))

endmodule

`default_nettype wire

>>> rtl/srb_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/srb_angle_index.sv
// Rounded angle-to-index scale: (product + half) / 18000 by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module srb_angle_index (
   input  wire logic [srb_pkg::PROD_W-1:0] prod,
   output logic      [srb_pkg::IDX_W-1:0]  idx
);
   import srb_pkg::*;

   localparam int FULL_W = PROD_W + RECIP_W;

   logic [PROD_W-1:0] num;
   logic [FULL_W-1:0] full;

   assign num  = prod + ANGLE_HALF;
   assign full = FULL_W'(num) * FULL_W'(RECIP);
   assign idx  = full[RECIP_SHIFT +: IDX_W];

endmodule

`default_nettype wire

>>> tb/scan_ring_buffer_with_angle_lookup_checker.sv
// Response checker for the scan ring buffer: watches req, rsp and csr, predicts and compares.
`timescale 1ns / 1ps

module scan_ring_buffer_with_angle_lookup_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [1:0]                     req_command,
   input  wire logic [srb_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic                           req_sample_last,
   input  wire logic [srb_pkg::ANGLE_W-1:0]    req_angle,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [srb_pkg::SAMPLE_W-1:0]   rsp_value,
   input  wire logic [1:0]                     rsp_status,
   input  wire logic                           rsp_scan_last,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [srb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [srb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                           csr_pready,
   output int                                  fail_count,
   output int                                  words_checked,
   output int                                  readouts_waiting
);
   import srb_pkg::*;

   localparam int SLOTS       = DEF_BUFFER_SLOTS;
   localparam int DEPTH       = DEF_MAX_POINTS;
   localparam int MAX_REPORTS = 40;
   localparam logic [CSR_ADDR_W-1:0] RESOLUTION_ADDR = CSR_ADDR_W'(4 * REG_RESOLUTION);

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      status_type          status;
      logic                scan_last;
   } readout_type;

   readout_type         expected_readouts [$];
   logic [SAMPLE_W-1:0] scan_samples [SLOTS*DEPTH];
   int unsigned         stored_len [SLOTS];
   int unsigned         oldest_scan;
   int unsigned         newest_scan;
   int unsigned         fill_pos;     // 0: next push opens a slot
   int unsigned         drain_pos;
   int unsigned         scan_points;
   bit                  ring_empty;

   function automatic int unsigned points_for(input logic [RES_W-1:0] r);
      int unsigned step;
      int unsigned p;
      step = (r < 1) ? 1 : (r > 10) ? 10 : int'(r);
      p = 1800 / step + 1;
      return (p > DEPTH) ? DEPTH : p;
   endfunction

   // beyond the stored length a scan reads as zero
   function automatic logic [SAMPLE_W-1:0] stored_sample(input int unsigned slot,
                                                         input int unsigned pos);
      if (pos >= stored_len[slot] || pos >= DEPTH) return '0;
      return scan_samples[slot*DEPTH + pos];
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic predict_readout(input cmd_type cmd, input logic [SAMPLE_W-1:0] smp,
                                  input logic lst, input logic [ANGLE_W-1:0] ang,
                                  output readout_type r);
      int unsigned idx;
      r = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (fill_pos == 0) begin
               if (ring_empty) begin
                  newest_scan = oldest_scan;
                  ring_empty = 1'b0;
                  drain_pos = 0;
               end else begin
                  newest_scan = (newest_scan + 1) % SLOTS;
                  // new slot lands on the oldest scan: drop it, restart any pop
                  if (newest_scan == oldest_scan) begin
                     oldest_scan = (oldest_scan + 1) % SLOTS;
                     drain_pos = 0;
                  end
               end
               stored_len[newest_scan] = 0;
            end
            if (fill_pos < scan_points) begin
               scan_samples[newest_scan*DEPTH + fill_pos] = smp;
               fill_pos++;
               stored_len[newest_scan] = fill_pos;
            end
            if (lst) fill_pos = 0;
         end
         CMD_POP: begin
            if (ring_empty) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = stored_sample(oldest_scan, drain_pos);
               if (drain_pos + 1 >= scan_points) begin
                  r.scan_last = 1'b1;
                  drain_pos = 0;
                  // freeing the only slot also ends a push in progress
                  if (oldest_scan == newest_scan) begin
                     ring_empty = 1'b1;
                     fill_pos = 0;
                  end else begin
                     oldest_scan = (oldest_scan + 1) % SLOTS;
                  end
               end else begin
                  drain_pos++;
               end
            end
         end
         CMD_READ: begin
            if (ring_empty) begin
               r.status = ST_EMPTY;
            end else if (ang > ANGLE_MAX) begin
               r.status = ST_BAD_ANGLE;
            end else begin
               // round to nearest, halves up
               idx = (int'(ang) * (scan_points - 1) + 9000) / 18000;
               r.value = stored_sample(newest_scan, idx);
            end
         end
         CMD_CLEAR: begin
            ring_empty = 1'b1;
            fill_pos = 0;
            drain_pos = 0;
         end
      endcase
   endtask

   always @(posedge clock) begin
      readout_type want;
      if (reset) begin
         expected_readouts.delete();
         for (int i = 0; i < SLOTS; i++) stored_len[i] = 0;
         oldest_scan = 0;
         newest_scan = 0;
         fill_pos = 0;
         drain_pos = 0;
         ring_empty = 1'b1;
         scan_points = points_for(RES_RESET);
         fail_count = 0;
         words_checked = 0;
      end else begin
         // result first: a word taken at this edge cannot have its answer out yet
         if (rsp_valid && !rsp_stall) begin
            if (expected_readouts.size() == 0) begin
               report_mismatch($sformatf("response word with nothing expected, value %h",
                                         rsp_value));
            end else begin
               want = expected_readouts.pop_front();
               if (rsp_value !== want.value)
                  report_mismatch($sformatf("word %0d value got %h want %h",
                                            words_checked, rsp_value, want.value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("word %0d status got %0d want %0d",
                                            words_checked, rsp_status, want.status));
               if (rsp_scan_last !== want.scan_last)
                  report_mismatch($sformatf("word %0d scan_last got %b want %b",
                                            words_checked, rsp_scan_last, want.scan_last));
               words_checked++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == RESOLUTION_ADDR)
            scan_points = points_for(csr_pwdata[RES_W-1:0]);
         if (req_valid && !req_stall) begin
            predict_readout(cmd_type'(req_command), req_sample_value, req_sample_last,
                            req_angle, want);
            expected_readouts.push_back(want);
         end
      end
      readouts_waiting <= expected_readouts.size();
   end

endmodule

>>> tb/scan_ring_buffer_with_angle_lookup_test.sv
// Testbench top for the scan ring buffer: clock, reset, stimulus, csr writes and verdict.
`timescale 1ns / 1ps

module scan_ring_buffer_with_angle_lookup_test;
   import srb_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 250;
   localparam int PHASE_WORDS = 175;
   localparam int PHASES      = 6;
   localparam logic [CSR_ADDR_W-1:0] RESOLUTION_ADDR = CSR_ADDR_W'(4 * REG_RESOLUTION);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_command;
   logic [SAMPLE_W-1:0]   req_sample_value;
   logic                  req_sample_last;
   logic [ANGLE_W-1:0]    req_angle;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SAMPLE_W-1:0]   rsp_value;
   logic [1:0]            rsp_status;
   logic                  rsp_scan_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int words_checked;
   int readouts_waiting;
   int words_sent;
   int settings_used;
   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_requests;
   int holds_done;
   int quiet_cycles;
   logic [RES_W-1:0] phase_res [PHASES];

   scan_ring_buffer_with_angle_lookup uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sample_value (req_sample_value),
      .req_sample_last  (req_sample_last),
      .req_angle        (req_angle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .rsp_scan_last    (rsp_scan_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   scan_ring_buffer_with_angle_lookup_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sample_value (req_sample_value),
      .req_sample_last  (req_sample_last),
      .req_angle        (req_angle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .rsp_scan_last    (rsp_scan_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .fail_count       (fail_count),
      .words_checked    (words_checked),
      .readouts_waiting (readouts_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall, or a long hold-off when one is requested
   initial begin
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // ends the run when neither channel moves a word for too long
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_word(input cmd_type cmd, input logic [SAMPLE_W-1:0] smp,
                            input logic lst, input logic [ANGLE_W-1:0] ang);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_sample_value <= smp;
      req_sample_last  <= lst;
      req_angle        <= ang;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // stop offering and wait until every response has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readouts_waiting != 0) @(posedge clock);
   endtask

   task automatic write_resolution(input logic [RES_W-1:0] r);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RESOLUTION_ADDR;
      csr_pwdata  <= CSR_DATA_W'(r);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // mostly well-formed scans, pop runs and lookups; some noise and unterminated scans
   task automatic run_phase(input int budget, input bit with_hold, input int points);
      int start;
      int kind;
      int len;
      int n;
      int left;
      bit ends;
      logic [ANGLE_W-1:0] ang;
      start = words_sent;
      while (words_sent - start < budget) begin
         if (with_hold && words_sent - start >= 20) begin
            hold_requests++;
            with_hold = 1'b0;
         end
         // long bursts are cut at the end of the phase
         left = budget - (words_sent - start);
         kind = $urandom_range(99);
         if (kind < 45) begin
            if (kind >= 35 && points <= 301)
               len = $urandom_range(points + 4, points - 2);
            else
               len = $urandom_range(8, 1);
            if (len > left) len = left;
            ends = ($urandom_range(9) != 0);
            for (int i = 0; i < len; i++)
               send_word(CMD_PUSH, pick_sample(), ends && (i == len - 1),
                         ANGLE_W'($urandom));
         end else if (kind < 65) begin
            n = (points <= 301 && $urandom_range(2) == 0) ? points : $urandom_range(12, 1);
            if (n > left) n = left;
            repeat (n)
               send_word(CMD_POP, SAMPLE_W'($urandom), 1'($urandom), ANGLE_W'($urandom));
         end else if (kind < 85) begin
            repeat ($urandom_range(6, 1)) begin
               case ($urandom_range(9))
                  0:       ang = '0;
                  1:       ang = ANGLE_MAX;
                  2, 3:    ang = ANGLE_W'($urandom_range(32767, 18001));
                  default: ang = ANGLE_W'($urandom_range(18000));
               endcase
               send_word(CMD_READ, SAMPLE_W'($urandom), 1'($urandom), ang);
            end
         end else if (kind < 88) begin
            send_word(CMD_CLEAR, SAMPLE_W'($urandom), 1'($urandom), ANGLE_W'($urandom));
         end else begin
            repeat ($urandom_range(4, 1))
               send_word(cmd_type'($urandom_range(3)), SAMPLE_W'($urandom), 1'($urandom),
                         ANGLE_W'($urandom));
         end
      end
   endtask

   initial begin
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_PUSH;
      req_sample_value = '0;
      req_sample_last = 1'b0;
      req_angle = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      words_sent = 0;
      settings_used = 0;
      hold_requests = 0;
      sender_idle_pct = 11;
      receiver_idle_pct = 46;
      phase_res[0] = 4'd15;
      phase_res[1] = 4'd9;
      phase_res[2] = 4'd1;
      phase_res[3] = 4'd0;
      phase_res[4] = RES_W'($urandom_range(8, 2));
      phase_res[5] = 4'd10;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset resolution
      send_word(CMD_POP,   16'h1111, 1'b1, '1);           // empty buffer
      send_word(CMD_READ,  16'h2222, 1'b0, '1);           // empty wins over bad angle
      send_word(CMD_PUSH,  16'h0000, 1'b0, '1);
      send_word(CMD_PUSH,  16'hffff, 1'b0, '0);
      send_word(CMD_PUSH,  16'h1234, 1'b1, '0);           // short scan of three
      send_word(CMD_READ,  '0, 1'b0, ANGLE_W'(0));
      send_word(CMD_READ,  '0, 1'b0, ANGLE_W'(100));
      send_word(CMD_READ,  '0, 1'b0, ANGLE_W'(50));       // exact half rounds up
      send_word(CMD_READ,  '0, 1'b0, ANGLE_MAX);          // past stored length
      send_word(CMD_READ,  '0, 1'b0, ANGLE_W'(18001));
      send_word(CMD_READ,  '1, 1'b1, '1);
      repeat (4) send_word(CMD_POP, '0, 1'b0, '0);        // last one reads zero
      send_word(CMD_CLEAR, '1, 1'b1, '1);
      send_word(CMD_READ,  '0, 1'b0, ANGLE_W'(9000));
      send_word(CMD_PUSH,  16'h5a5a, 1'b1, '0);
      send_word(CMD_PUSH,  16'ha5a5, 1'b0, '0);
      send_word(CMD_PUSH,  16'h8001, 1'b1, '0);
      send_word(CMD_READ,  '0, 1'b0, ANGLE_W'(100));
      send_word(CMD_POP,   '0, 1'b0, '0);
      send_word(CMD_CLEAR, '0, 1'b0, '0);
      drain_results();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 2) begin
            sender_idle_pct = 46;
            receiver_idle_pct = 11;
         end else if (ph == 4) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         write_resolution(phase_res[ph]);
         r = phase_res[ph];
         if (r < 1) r = 1;
         else if (r > 10) r = 10;
         run_phase(PHASE_WORDS, ph == 0 || ph == 4, 1800 / r + 1);
         drain_results();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d request words over %0d resolution settings, %0d responses compared.",
               words_sent, settings_used, words_checked);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
